>>> hw/rtl/srw_pkg.sv
`default_nettype none

package srw_pkg;

	// Default sizes of the block.
	localparam int SEQ_BITS_DEF     = 8;
	localparam int WINDOW_MAX_DEF   = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Window size register.
	localparam int             CFG_BITS     = 5;
	localparam logic [CFG_BITS-1:0] WINDOW_RESET = 5'd4;

	// Result codes.
	typedef enum logic [1:0] {
		KIND_ACK_NEW   = 2'd0,
		KIND_ACK_DUP   = 2'd1,
		KIND_REACK_OLD = 2'd2,
		KIND_DELIVER   = 2'd3
	} kind_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK,
		ST_DLV
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic load_ack;
		logic load_dlv;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_ignore;
		logic ack_more;
		logic dlv_more;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/srw_ctrl.sv
`default_nettype none

module srw_ctrl
	import srw_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic in_valid,
	output logic       in_stall,
	input  wire  sts_t sts,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && !sts.in_ignore) begin
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (sts.out_free) begin
					cmd.load_ack = 1'b1;
					state_d      = sts.ack_more ? ST_DLV : ST_IDLE;
				end
			end
			ST_DLV: begin
				if (sts.out_free) begin
					cmd.load_dlv = 1'b1;
					state_d      = sts.dlv_more ? ST_DLV : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/srw_dp.sv
`default_nettype none

module srw_dp
	import srw_pkg::*;
#(
	parameter int SEQ_BITS     = SEQ_BITS_DEF,
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  cmd_t                    cmd,
	output sts_t                          sts,
	input  wire  logic [SEQ_BITS-1:0]     seq_number,
	input  wire  logic [PAYLOAD_BITS-1:0] payload,
	input  wire  logic                    cfg_we,
	input  wire  logic [CFG_BITS-1:0]     cfg_data,
	input  wire  logic                    out_stall,
	output logic                          out_valid,
	output logic [1:0]                    result_kind,
	output logic [SEQ_BITS-1:0]           result_seq,
	output logic [PAYLOAD_BITS-1:0]       delivered_payload,
	output logic                          last
);

	localparam int IDXW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int HALF = 1 << (SEQ_BITS - 1);
	localparam int WLIM = (WINDOW_MAX < HALF) ? WINDOW_MAX : HALF;
	localparam logic [IDXW:0]   WMAX_W = (IDXW + 1)'(WINDOW_MAX);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(WINDOW_MAX - 1);

	// Window state: slots form a ring, head is the slot of the window base.
	logic [CFG_BITS-1:0]     ws_q;
	logic [SEQ_BITS-1:0]     base_q;
	logic [IDXW-1:0]         head_q;
	logic [WINDOW_MAX-1:0]   rcv_q;
	logic [PAYLOAD_BITS-1:0] mem [WINDOW_MAX];
	logic [PAYLOAD_BITS-1:0] rd_q;

	// Acknowledgement held for the frame being worked on.
	kind_t               kind_q;
	logic [SEQ_BITS-1:0] seq_q;

	// Output register.
	logic                    out_valid_q;
	kind_t                   out_kind_q;
	logic [SEQ_BITS-1:0]     out_seq_q;
	logic [PAYLOAD_BITS-1:0] out_pay_q;
	logic                    out_last_q;

	logic [SEQ_BITS-1:0] off;
	logic [CFG_BITS-1:0] ws_c;
	logic                in_win;
	logic                is_old;
	logic [IDXW:0]       phys_sum;
	logic [IDXW-1:0]     phys;
	logic [IDXW-1:0]     head_inc;
	logic [IDXW-1:0]     rd_addr;
	kind_t               kind_in;
	logic                out_free;

	// Classify the arriving frame against the window.
	always_comb begin
		off      = seq_number - base_q;
		ws_c     = (ws_q == '0) ? CFG_BITS'(1) : ws_q;
		in_win   = (32'(off) < 32'(ws_c)) && (32'(off) < 32'(WLIM));
		is_old   = off[SEQ_BITS-1];
		phys_sum = (IDXW + 1)'(head_q) + (IDXW + 1)'(off);
		phys     = (phys_sum >= WMAX_W) ? IDXW'(phys_sum - WMAX_W) : IDXW'(phys_sum);
		head_inc = (head_q == LAST_IDX) ? '0 : head_q + IDXW'(1);
		rd_addr  = cmd.load_dlv ? head_inc : head_q;
		if (in_win) begin
			kind_in = rcv_q[phys] ? KIND_ACK_DUP : KIND_ACK_NEW;
		end else begin
			kind_in = KIND_REACK_OLD;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Status toward the controller.
	always_comb begin
		sts.in_ignore = !in_win && !is_old;
		sts.ack_more  = (kind_q != KIND_REACK_OLD) && rcv_q[head_q];
		sts.dlv_more  = rcv_q[head_inc];
		sts.out_free  = out_free;
	end

	// Control state: register, base, ring head, received flags and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WINDOW_RESET;
			base_q      <= '0;
			head_q      <= '0;
			rcv_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_data;
			end
			if (cmd.accept && in_win) begin
				rcv_q[phys] <= 1'b1;
			end
			if (cmd.load_dlv) begin
				rcv_q[head_q] <= 1'b0;
				head_q        <= head_inc;
				base_q        <= base_q + SEQ_BITS'(1);
			end
			if (cmd.load_ack || cmd.load_dlv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload store; the read always follows the head the next cycle will see.
	always_ff @(posedge clk) begin
		if (cmd.accept && in_win && !rcv_q[phys]) begin
			mem[phys] <= payload;
		end
		rd_q <= mem[rd_addr];
	end

	// Latch the acknowledgement of an accepted frame.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind_in;
			seq_q  <= seq_number;
		end
	end

	// Output data register.
	always_ff @(posedge clk) begin
		if (cmd.load_ack) begin
			out_kind_q <= kind_q;
			out_seq_q  <= seq_q;
			out_pay_q  <= '0;
			out_last_q <= !sts.ack_more;
		end else if (cmd.load_dlv) begin
			out_kind_q <= KIND_DELIVER;
			out_seq_q  <= base_q;
			out_pay_q  <= rd_q;
			out_last_q <= !sts.dlv_more;
		end
	end

	assign out_valid         = out_valid_q;
	assign result_kind       = out_kind_q;
	assign result_seq        = out_seq_q;
	assign delivered_payload = out_pay_q;
	assign last              = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/selective_repeat_receive_window.sv
`default_nettype none

// Selective-repeat ARQ receiver. Each accepted frame (seq_number, payload) gives
// no result when it lies beyond the window, one acknowledgement when it is old or a
// duplicate, or one acknowledgement followed by in-order deliveries of every
// consecutive buffered frame from the window base; last marks the final result of
// a frame. The input is taken in ST_IDLE, the acknowledgement is loaded in ST_ACK
// and each delivery in ST_DLV; in_stall stays high until the last result of the
// frame is loaded, and an ignored frame leaves the input open. Deliveries are paced
// by the single read port of the payload store, which is read one slot ahead. The
// window size register (cfg_data) resets to 4 and is clamped to 1..min(WINDOW_MAX,
// half the sequence space); the user is to write it only when idle, which the block
// does not enforce. Received flags clear at reset; no clearing pass is needed.
module selective_repeat_receive_window
	import srw_pkg::*;
#(
	parameter int SEQ_BITS     = SEQ_BITS_DEF,
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  logic                    in_valid,
	output logic                          in_stall,
	input  wire  logic [SEQ_BITS-1:0]     seq_number,
	input  wire  logic [PAYLOAD_BITS-1:0] payload,
	output logic                          out_valid,
	input  wire  logic                    out_stall,
	output logic [1:0]                    result_kind,
	output logic [SEQ_BITS-1:0]           result_seq,
	output logic [PAYLOAD_BITS-1:0]       delivered_payload,
	output logic                          last,
	input  wire  logic                    cfg_valid,
	output logic                          cfg_ready,
	input  wire  logic [CFG_BITS-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// The register may be written at any time the block is idle.
	assign cfg_ready = 1'b1;

	srw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	srw_dp #(
		.SEQ_BITS     (SEQ_BITS),
		.WINDOW_MAX   (WINDOW_MAX),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.seq_number        (seq_number),
		.payload           (payload),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.result_kind       (result_kind),
		.result_seq        (result_seq),
		.delivered_payload (delivered_payload),
		.last              (last)
	);

`ifndef NO_ASSERTIONS
	// A frame that causes results closes the input until its results are out.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !sts.in_ignore) |=> in_stall)
		else $error("input not stalled while a frame is in work");

	// A new result is loaded only when the pending one is taken or absent.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_ack || cmd.load_dlv) |-> sts.out_free)
		else $error("pending result overwritten");

	// A delivery command shows up as a delivery result.
	a_dlv_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_dlv |=> (out_valid && result_kind == KIND_DELIVER))
		else $error("delivery not presented");
`endif

endmodule

`default_nettype wire
